### hw/rtl/tpc_pkg.sv
// Package for the trapezoid profile calculator: shared constants and the
// sideband word that travels alongside the divider lanes. No dependencies.
package tpc_pkg;

    localparam int unsigned RATE_W     = 16;
    localparam int unsigned COUNT_W    = 24;
    localparam int unsigned ACCEL_W    = 24;
    localparam int unsigned FACTOR_W   = 17;
    localparam logic [RATE_W-1:0] RATE_MAX       = 16'hFFFF;
    localparam logic [RATE_W-1:0] MIN_RATE_RESET = 16'd120;

    // Everything the correction stages need besides the quotients and remainders.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               accel_zero;
        logic               acc_neg;
        logic               dec_neg;
        logic               x_nonpos;
        logic               x_over;
        logic [RATE_W-1:0]  entry_rate;
        logic [RATE_W-1:0]  exit_rate;
        logic               busy;
    } t_side;

endpackage

### hw/rtl/trapezoid_profile_calculator_unit.sv
// Top level of the trapezoid profile calculator: rate scaling, squares,
// numerators, three divider lanes and the final selection. Uses tpc_pkg,
// tpc_div and tpc_side_delay.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+---------------------------
//  segment   | i_nominal_rate .. i_segment_busy       | start high, busy low
//  profile   | o_accelerate_until .. o_applied        | o_valid for one cycle
//  config    | i_cfg_wdata (min_step_rate)            | i_cfg_we high
//
// One word enters per cycle while busy is low; each result is strobed on o_valid
// after the 32-stage divider lanes, one quotient bit a stage, plus five stages in
// front and two behind.
// Reset is synchronous, active low; it empties the pipeline, holds busy high
// and loads min_step_rate with 120. The receiver cannot stall, so nothing stalls.
module trapezoid_profile_calculator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_nominal_rate,
    input  logic [16:0] i_entry_factor,
    input  logic [16:0] i_exit_factor,
    input  logic [23:0] i_accel_steps_per_sq_second,
    input  logic [23:0] i_total_steps,
    input  logic        i_segment_busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    output logic signed [31:0] o_accelerate_until,
    output logic signed [31:0] o_decelerate_after,
    output logic [15:0] o_entry_rate,
    output logic [15:0] o_exit_rate,
    output logic        o_applied
);
    import tpc_pkg::*;

    localparam int unsigned LAT = 39;

    logic [RATE_W-1:0] r_min_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_rate <= MIN_RATE_RESET;
        else if (i_cfg_we) r_min_rate <= i_cfg_wdata;
    end

    assign busy = !i_rst_n;

    // stage 1: input register
    logic               r1_valid;
    logic [15:0]        r1_nom;
    logic [16:0]        r1_ef, r1_xf;
    logic [23:0]        r1_a, r1_count;
    logic               r1_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else r1_valid <= start && !busy;
    end
    always_ff @(posedge i_clk) begin
        r1_nom   <= i_nominal_rate;
        r1_ef    <= i_entry_factor;
        r1_xf    <= i_exit_factor;
        r1_a     <= i_accel_steps_per_sq_second;
        r1_count <= i_total_steps;
        r1_busy  <= i_segment_busy;
    end

    // stage 2: products
    logic        r2_valid;
    logic [32:0] r2_prod_i, r2_prod_f;
    logic [31:0] r2_n2;
    logic [23:0] r2_a, r2_count;
    logic        r2_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else r2_valid <= r1_valid;
    end
    always_ff @(posedge i_clk) begin
        r2_prod_i <= 33'(r1_nom) * 33'(r1_ef);
        r2_prod_f <= 33'(r1_nom) * 33'(r1_xf);
        r2_n2     <= 32'(r1_nom) * 32'(r1_nom);
        r2_a      <= r1_a;
        r2_count  <= r1_count;
        r2_busy   <= r1_busy;
    end

    // stage 3: ceil, saturate, raise to minimum
    logic [33:0] c3_sum_i, c3_sum_f;
    logic [17:0] c3_up_i, c3_up_f;
    logic [15:0] c3_ir, c3_fr;

    always_comb begin
        c3_sum_i = 34'(r2_prod_i) + 34'(RATE_MAX);
        c3_sum_f = 34'(r2_prod_f) + 34'(RATE_MAX);
        c3_up_i  = c3_sum_i[33:16];
        c3_up_f  = c3_sum_f[33:16];
        c3_ir    = (c3_up_i > 18'(RATE_MAX)) ? RATE_MAX : c3_up_i[15:0];
        c3_fr    = (c3_up_f > 18'(RATE_MAX)) ? RATE_MAX : c3_up_f[15:0];
        if (c3_ir < r_min_rate) c3_ir = r_min_rate;
        if (c3_fr < r_min_rate) c3_fr = r_min_rate;
    end

    logic        r3_valid;
    logic [15:0] r3_ir, r3_fr;
    logic [31:0] r3_n2;
    logic [23:0] r3_a, r3_count;
    logic        r3_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else r3_valid <= r2_valid;
    end
    always_ff @(posedge i_clk) begin
        r3_ir    <= c3_ir;
        r3_fr    <= c3_fr;
        r3_n2    <= r2_n2;
        r3_a     <= r2_a;
        r3_count <= r2_count;
        r3_busy  <= r2_busy;
    end

    // stage 4: squares and 2a*count
    logic        r4_valid;
    logic [31:0] r4_i2, r4_f2, r4_n2;
    logic [48:0] r4_p;
    logic [15:0] r4_ir, r4_fr;
    logic [23:0] r4_a, r4_count;
    logic        r4_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else r4_valid <= r3_valid;
    end
    always_ff @(posedge i_clk) begin
        r4_i2    <= 32'(r3_ir) * 32'(r3_ir);
        r4_f2    <= 32'(r3_fr) * 32'(r3_fr);
        r4_p     <= 49'({r3_a, 1'b0}) * 49'(r3_count);
        r4_n2    <= r3_n2;
        r4_ir    <= r3_ir;
        r4_fr    <= r3_fr;
        r4_a     <= r3_a;
        r4_count <= r3_count;
        r4_busy  <= r3_busy;
    end

    // stage 5: signed numerators, split into sign and magnitude
    logic signed [32:0] c5_num_a, c5_num_d, c5_fi;
    logic signed [50:0] c5_num_x;
    logic [32:0]        c5_mag_a, c5_mag_d;

    always_comb begin
        c5_num_a = $signed({1'b0, r4_n2}) - $signed({1'b0, r4_i2});
        c5_num_d = $signed({1'b0, r4_n2}) - $signed({1'b0, r4_f2});
        c5_fi    = $signed({1'b0, r4_f2}) - $signed({1'b0, r4_i2});
        c5_num_x = $signed({2'b00, r4_p}) + 51'(c5_fi);
        c5_mag_a = c5_num_a[32] ? 33'(-c5_num_a) : 33'(c5_num_a);
        c5_mag_d = c5_num_d[32] ? 33'(-c5_num_d) : 33'(c5_num_d);
    end

    logic        r5_valid;
    logic [31:0] r5_mag_a, r5_mag_d;
    logic [49:0] r5_mag_x;
    logic [24:0] r5_den2;
    logic [25:0] r5_den4;
    t_side       r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_valid <= 1'b0;
        else r5_valid <= r4_valid;
    end
    always_ff @(posedge i_clk) begin
        r5_mag_a <= c5_mag_a[31:0];
        r5_mag_d <= c5_mag_d[31:0];
        r5_mag_x <= c5_num_x[49:0];
        r5_den2  <= {r4_a, 1'b0};
        r5_den4  <= {r4_a, 2'b00};
        r5_side.count      <= r4_count;
        r5_side.accel_zero <= (r4_a == '0);
        r5_side.acc_neg    <= c5_num_a[32];
        r5_side.dec_neg    <= c5_num_d[32];
        r5_side.x_nonpos   <= (c5_num_x <= 0);
        r5_side.x_over     <= $signed(50'(c5_fi)) > $signed({1'b0, r4_p});
        r5_side.entry_rate <= r4_ir;
        r5_side.exit_rate  <= r4_fr;
        r5_side.busy       <= r4_busy;
    end

    // divider lanes, all 32 stages deep so they line up with the sideband
    logic [31:0] w_q_a, w_r_a, w_q_d, w_r_d;
    logic [31:0] w_q_x;
    logic [49:0] w_r_x;
    logic        w_dv_valid;
    t_side       w_dv_side;

    tpc_div #(.NUM_W(32), .DEN_W(25), .QUO_W(32)) u_div_acc (
        .i_clk(i_clk), .i_num(r5_mag_a), .i_den(r5_den2), .o_quo(w_q_a), .o_rem(w_r_a)
    );
    tpc_div #(.NUM_W(32), .DEN_W(25), .QUO_W(32)) u_div_dec (
        .i_clk(i_clk), .i_num(r5_mag_d), .i_den(r5_den2), .o_quo(w_q_d), .o_rem(w_r_d)
    );
    tpc_div #(.NUM_W(50), .DEN_W(26), .QUO_W(32)) u_div_x (
        .i_clk(i_clk), .i_num(r5_mag_x), .i_den(r5_den4), .o_quo(w_q_x), .o_rem(w_r_x)
    );
    tpc_side_delay #(.DEPTH(32)) u_side (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r5_valid), .i_side(r5_side),
        .o_valid(w_dv_valid), .o_side(w_dv_side)
    );

    // stage 38: floor and ceil corrections, intersection clamp
    logic signed [33:0] c38_acc, c38_dec;
    logic [23:0]        c38_x;
    logic [32:0]        c38_qa_up, c38_qd_up;
    logic [24:0]        c38_qx_up;

    always_comb begin
        c38_qa_up = 33'(w_q_a) + 33'(w_r_a != '0);
        c38_qd_up = 33'(w_q_d) + 33'(w_r_d != '0);
        // the quotient fits in 24 bits whenever it is used
        c38_qx_up = 25'(w_q_x[23:0]) + 25'(w_r_x != '0);
        c38_acc = w_dv_side.acc_neg ? -$signed({2'b00, w_q_a}) : $signed({1'b0, c38_qa_up});
        c38_dec = w_dv_side.dec_neg ? -$signed({1'b0, c38_qd_up}) : $signed({2'b00, w_q_d});
        if (w_dv_side.accel_zero) begin
            c38_acc = '0;
            c38_dec = '0;
        end
        if (w_dv_side.x_nonpos) c38_x = '0;
        else if (w_dv_side.x_over) c38_x = w_dv_side.count;
        else c38_x = c38_qx_up[23:0];
    end

    logic               r38_valid;
    logic signed [33:0] r38_acc, r38_dec;
    logic [23:0]        r38_x;
    t_side              r38_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r38_valid <= 1'b0;
        else r38_valid <= w_dv_valid;
    end
    always_ff @(posedge i_clk) begin
        r38_acc  <= c38_acc;
        r38_dec  <= c38_dec;
        r38_x    <= c38_x;
        r38_side <= w_dv_side;
    end

    // stage 39: plateau check, selection, saturation
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] res;
        if (v > 35'sh07FFFFFFF) res = 32'h7FFF_FFFF;
        else if (v < -35'sh080000000) res = 32'h8000_0000;
        else res = v[31:0];
        return res;
    endfunction

    logic signed [34:0] c39_cnt, c39_plateau, c39_after, c39_acc_sel, c39_dec_sel;

    always_comb begin
        c39_cnt     = $signed({11'd0, r38_side.count});
        c39_plateau = c39_cnt - 35'(r38_acc) - 35'(r38_dec);
        c39_after   = c39_cnt - 35'(r38_dec);
        if (c39_plateau < 0) begin
            c39_acc_sel = $signed({11'd0, r38_x});
            c39_dec_sel = $signed({11'd0, r38_x});
        end else begin
            c39_acc_sel = 35'(r38_acc);
            c39_dec_sel = c39_after;
        end
    end

    logic r39_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r39_valid <= 1'b0;
        else r39_valid <= r38_valid;
    end
    always_ff @(posedge i_clk) begin
        o_accelerate_until <= sat32(c39_acc_sel);
        o_decelerate_after <= sat32(c39_dec_sel);
        o_entry_rate       <= r38_side.entry_rate;
        o_exit_rate        <= r38_side.exit_rate;
        o_applied          <= !r38_side.busy;
    end

    assign o_valid = r39_valid;

    a_lat : assert property (@(posedge i_clk) o_valid |-> $past(start && !busy, LAT))
        else $error("result word without a matching accept");
    a_rst : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word right after reset");
    a_order : assert property (@(posedge i_clk)
        o_valid |-> o_accelerate_until <= o_decelerate_after)
        else $error("acceleration ends after deceleration starts");
    a_min : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_rate >= r_min_rate) && (o_exit_rate >= r_min_rate))
        else $error("rate below minimum");
    a_applied : assert property (@(posedge i_clk)
        o_valid |-> o_applied == !$past(i_segment_busy, LAT))
        else $error("applied flag does not follow segment busy");

endmodule

### hw/rtl/tpc_div.sv
// Pipelined restoring divider for the trapezoid profile calculator.
// One quotient bit per register stage; no package dependency.
module tpc_div #(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 25,
    parameter int unsigned QUO_W = 32
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic [NUM_W-1:0] o_rem
);

    localparam int unsigned CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] diff;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign shifted = CMP_W'(den_in) << (QUO_W - 1 - s);
        assign take    = CMP_W'(rem_in) >= shifted;
        assign diff    = CMP_W'(rem_in) - shifted;

        always_ff @(posedge i_clk) begin
            r_rem[s] <= take ? diff[NUM_W-1:0] : rem_in;
            r_den[s] <= den_in;
            r_quo[s] <= quo_in | (take ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);
        end
    end

    assign o_quo = r_quo[QUO_W-1];
    assign o_rem = r_rem[QUO_W-1];

endmodule

### hw/rtl/tpc_side_delay.sv
// Valid and sideband delay line that runs beside the divider lanes.
// Depends on tpc_pkg for the sideband word.
module tpc_side_delay #(
    parameter int unsigned DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tpc_pkg::t_side i_side,
    output logic          o_valid,
    output tpc_pkg::t_side o_side
);
    import tpc_pkg::*;

    logic  r_valid [DEPTH];
    t_side r_side  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_valid[k] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int k = 1; k < DEPTH; k++) r_side[k] <= r_side[k-1];
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_side  = r_side[DEPTH-1];

endmodule

### tb/tb.sv
// Testbench for trapezoid_profile_calculator_unit: drives directed segment words and
// random bursts, predicts each profile and checks it against the block's results.
// Depends on tpc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
    import tpc_pkg::*;

    localparam int LATENCY   = 39;
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        logic signed [31:0] accel_until;
        logic signed [31:0] decel_after;
        logic [15:0]        entry_rate;
        logic [15:0]        exit_rate;
        logic               applied;
    } t_profile;

    class t_profile_board;
        t_profile pending[$];
        int       mismatches = 0;

        function void note_segment(t_profile p);
            pending.push_back(p);
        endfunction

        function void check_profile(t_profile got);
            t_profile want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected profile word: au=%0d da=%0d",
                             got.accel_until, got.decel_after);
                return;
            end
            want = pending.pop_front();
            if (got.accel_until !== want.accel_until || got.decel_after !== want.decel_after
                || got.entry_rate !== want.entry_rate || got.exit_rate !== want.exit_rate
                || got.applied !== want.applied) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"profile mismatch: exp au=%0d da=%0d ir=%0d fr=%0d ap=%0b",
                              "  got au=%0d da=%0d ir=%0d fr=%0d ap=%0b"},
                             want.accel_until, want.decel_after, want.entry_rate,
                             want.exit_rate, want.applied, got.accel_until,
                             got.decel_after, got.entry_rate, got.exit_rate, got.applied);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [15:0] i_nominal_rate = 0;
    logic [16:0] i_entry_factor = 0;
    logic [16:0] i_exit_factor = 0;
    logic [23:0] i_accel_steps_per_sq_second = 0;
    logic [23:0] i_total_steps = 0;
    logic        i_segment_busy = 0;
    logic        i_cfg_we = 0;
    logic [15:0] i_cfg_wdata = 0;
    logic        o_valid;
    logic signed [31:0] o_accelerate_until;
    logic signed [31:0] o_decelerate_after;
    logic [15:0] o_entry_rate;
    logic [15:0] o_exit_rate;
    logic        o_applied;

    logic [15:0]    min_rate = MIN_RATE_RESET;
    t_profile_board board = new();
    int             cycles = 0;

    trapezoid_profile_calculator_unit uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_profile('{o_accelerate_until, o_decelerate_after, o_entry_rate,
                                   o_exit_rate, o_applied});
    end

    function automatic longint div_floor(longint num, longint den);
        longint q = num / den;
        if (num % den != 0 && num < 0) q -= 1;
        return q;
    endfunction

    function automatic longint div_ceil(longint num, longint den);
        longint q = num / den;
        if (num % den != 0 && num > 0) q += 1;
        return q;
    endfunction

    function automatic logic [15:0] clamp_rate(logic [15:0] nom, logic [16:0] factor);
        longint r = (longint'(nom) * longint'(factor) + 65535) >>> 16;
        if (r > 65535) r = 65535;
        if (r < longint'(min_rate)) r = longint'(min_rate);
        return r[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_profile plan_profile(logic [15:0] nom, logic [16:0] ef,
                                              logic [16:0] xf, logic [23:0] accel,
                                              logic [23:0] steps, logic seg_busy);
        t_profile p;
        longint a = longint'(accel);
        longint cnt = longint'(steps);
        longint n2, i2, f2, acc, dec, plateau;
        p.entry_rate = clamp_rate(nom, ef);
        p.exit_rate  = clamp_rate(nom, xf);
        n2 = longint'(nom) * longint'(nom);
        i2 = longint'(p.entry_rate) * longint'(p.entry_rate);
        f2 = longint'(p.exit_rate) * longint'(p.exit_rate);
        acc = 0;
        dec = 0;
        if (a != 0) begin
            acc = div_ceil(n2 - i2, 2 * a);
            dec = div_floor(n2 - f2, 2 * a);
        end
        plateau = cnt - acc - dec;
        if (plateau < 0) begin
            acc = div_ceil(2 * a * cnt - i2 + f2, 4 * a);
            if (acc < 0) acc = 0;
            if (acc > cnt) acc = cnt;
            plateau = 0;
        end
        p.accel_until = sat32(acc);
        p.decel_after = sat32(acc + plateau);
        p.applied = !seg_busy;
        return p;
    endfunction

    task automatic send_segment(logic [15:0] nom, logic [16:0] ef, logic [16:0] xf,
                                logic [23:0] accel, logic [23:0] steps, logic seg_busy);
        i_nominal_rate = nom;
        i_entry_factor = ef;
        i_exit_factor = xf;
        i_accel_steps_per_sq_second = accel;
        i_total_steps = steps;
        i_segment_busy = seg_busy;
        start = 1;
        do @(posedge i_clk); while (busy);
        board.note_segment(plan_profile(nom, ef, xf, accel, steps, seg_busy));
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic random_segment();
        logic [15:0] nom = 16'($urandom);
        logic [16:0] ef, xf;
        logic [23:0] accel, steps;
        case ($urandom_range(0, 3))
            0: ef = 17'($urandom_range(0, 65536));
            1: ef = 17'd65536;
            2: ef = 17'($urandom);
            default: ef = 17'($urandom_range(0, 1023));
        endcase
        xf = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        case ($urandom_range(0, 3))
            0: accel = 24'($urandom);
            1: accel = 24'($urandom_range(0, 4000));
            2: accel = '0;
            default: accel = 24'($urandom_range(1, 100));
        endcase
        steps = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000));
        send_segment(nom, ef, xf, accel, steps, $urandom_range(0, 3) == 0);
    endtask

    task automatic write_min_rate(logic [15:0] val);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_wdata = val;
        i_cfg_we = 1;
        @(negedge i_clk);
        i_cfg_we = 0;
        min_rate = val;
    endtask

    task automatic random_phase(int words);
        int sent = 0;
        while (sent < words) begin
            // burst, then an optional gap
            repeat ($urandom_range(1, 20)) begin
                random_segment();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    initial begin
        int drain;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        // directed: extremes and special cases
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(16'hFFFF, 17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
        send_segment(1000, 65536, 65536, 500, 100, 0);
        send_segment(1000, 0, 0, 0, 300, 0);
        send_segment(1000, 0, 0, 1, 24'hFFFFFF, 0);
        send_segment(16'hFFFF, 0, 0, 1, 24'hFFFFFF, 0);
        send_segment(5000, 17'h1FFFF, 100, 200, 50, 0);
        send_segment(5000, 98304, 0, 1000, 24'hFFFFFF, 1);
        send_segment(5000, 0, 0, 100, 3, 0);
        send_segment(100, 32768, 32768, 10, 10, 0);
        send_segment(40000, 1, 65535, 24'hFFFFFF, 1, 0);
        send_segment(40000, 65535, 1, 1, 0, 0);
        send_segment(16'h5555, 17'h0AAAA, 17'h15555, 24'hAAAAAA, 24'h555555, 1);
        random_phase(200);
        write_min_rate(0);
        send_segment(1000, 0, 0, 50, 100, 0);
        random_phase(200);
        write_min_rate(16'hFFFF);
        send_segment(1000, 0, 65536, 50, 100, 0);
        random_phase(200);
        write_min_rate(1);
        random_phase(100);
        write_min_rate(16'h5AA5);
        random_phase(100);
        drain = 0;
        while (board.pending.size() != 0 && drain < 10000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
